// ===== hdl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the streaming UTF-8 validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	// Byte classes decided by the front end
	typedef enum logic [2:0] {
		CLS_NUL,
		CLS_ASCII,
		CLS_CONT,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_BAD
	} uv_class_t;

	// One word as it travels through the queue
	typedef struct packed {
		uv_class_t   cls;
		logic [7:0]  data;
		logic        present;
		logic        last;
	} uv_item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} uv_qstat_t;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SUR_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SUR_HI  = 21'h00DFFF;

	// Continuation counts per sequence length
	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_TWO  = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR = 2'd3;

endpackage

// ===== hdl/utf8_stream_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker over a byte stream, one word per byte.
//
// Usage:
//   Input channel (in_valid/in_ready) carries data_byte, byte_present and
//   end_of_string. An empty string is a single word with byte_present low
//   and end_of_string high.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   error_seen tracks the string so far, string_done marks the closing
//   word and string_valid gives the verdict on it.
//   An accepted word passes through the queue, then the output register, to out_valid.
//   Throughput: one word per cycle while out_ready stays high, set by the decode step in the back end.
//   A queue of QUEUE_DEPTH words sits between classifier and decoder; when
//   the receiver stalls, the output register holds, the queue fills and
//   in_ready drops once it is full.
//   Reset clears the queue, the decode state and the output valid; the
//   block is ready to accept words as soon as reset is released.
// ----------------------------------------------------------------------------
module utf8_stream_validator #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       error_seen,
	output logic       string_done,
	output logic       string_valid
);
	import utf8v_pkg::*;

	uv_qstat_t qstat;
	uv_item_t  push_item;
	uv_item_t  pop_item;
	logic      push;
	logic      pop;

	// Classify incoming bytes
	utf8v_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.byte_present  (byte_present),
		.end_of_string (end_of_string),
		.qstat         (qstat),
		.push          (push),
		.push_item     (push_item)
	);

	// Buffer classified words
	utf8v_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	// Decode and report
	utf8v_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_item     (pop_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.error_seen   (error_seen),
		.string_done  (string_done),
		.string_valid (string_valid)
	);

endmodule

// ===== hdl/utf8v_front.sv =====
// ----------------------------------------------------------------------------
// utf8v_front
// Input side: accepts words and classifies each byte by its lead pattern.
// ----------------------------------------------------------------------------
module utf8v_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 byte_present,
	input  logic                 end_of_string,
	input  utf8v_pkg::uv_qstat_t qstat,
	output logic                 push,
	output utf8v_pkg::uv_item_t  push_item
);
	import utf8v_pkg::*;

	uv_class_t cls;

	// Classify the byte by its value range
	always_comb begin
		case (data_byte) inside
			8'h00:          cls = CLS_NUL;
			[8'h01:8'h7F]:  cls = CLS_ASCII;
			[8'h80:8'hBF]:  cls = CLS_CONT;
			[8'hC0:8'hDF]:  cls = CLS_LEAD2;
			[8'hE0:8'hEF]:  cls = CLS_LEAD3;
			[8'hF0:8'hF7]:  cls = CLS_LEAD4;
			default:        cls = CLS_BAD;
		endcase
	end

	// Take a word whenever the queue has room
	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_item.cls     = cls;
		push_item.data    = data_byte;
		push_item.present = byte_present;
		push_item.last    = end_of_string;
	end

endmodule

// ===== hdl/utf8v_queue.sv =====
// ----------------------------------------------------------------------------
// utf8v_queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module utf8v_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  utf8v_pkg::uv_item_t  push_item,
	input  logic                 pop,
	output utf8v_pkg::uv_item_t  pop_item,
	output utf8v_pkg::uv_qstat_t qstat
);
	import utf8v_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	uv_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign pop_item    = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/utf8v_back.sv =====
// ----------------------------------------------------------------------------
// utf8v_back
// Decode side: tracks the open sequence, checks code points, and registers
// one result word per queued word.
// ----------------------------------------------------------------------------
module utf8v_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8v_pkg::uv_qstat_t qstat,
	input  utf8v_pkg::uv_item_t  pop_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 error_seen,
	output logic                 string_done,
	output logic                 string_valid
);
	import utf8v_pkg::*;

	logic [1:0]      pend_q, pend_n;
	logic [1:0]      len_q, len_n;
	logic [CP_W-1:0] acc_q, acc_n;
	logic            err_q, err_n;

	logic [CP_W-1:0] acc_sh;
	logic [CP_W-1:0] min_cp;
	logic            cp_bad;
	logic            res_err, res_done, res_valid;
	logic            out_valid_q;
	logic            err_out_q, done_out_q, valid_out_q;

	// Pop when the output register is free or being drained
	assign pop = !qstat.empty && (!out_valid_q || out_ready);

	// Shift in the continuation payload and range-check the code point
	assign acc_sh = {acc_q[CP_W-7:0], pop_item.data[5:0]};

	always_comb begin
		case (len_q)
			SEQ_TWO:   min_cp = CP_MIN2;
			SEQ_THREE: min_cp = CP_MIN3;
			default:   min_cp = CP_MIN4;
		endcase
		cp_bad = (acc_sh < min_cp) || (acc_sh > CP_MAX) ||
			((acc_sh >= CP_SUR_LO) && (acc_sh <= CP_SUR_HI));
	end

	// Next decode state
	always_comb begin
		pend_n = pend_q;
		len_n  = len_q;
		acc_n  = acc_q;
		err_n  = err_q;
		if (pop_item.present && !err_q) begin
			if (pend_q == SEQ_NONE) begin
				case (pop_item.cls)
					CLS_ASCII: begin
					end
					CLS_LEAD2: begin
						pend_n = SEQ_TWO;
						len_n  = SEQ_TWO;
						acc_n  = CP_W'(pop_item.data[4:0]);
					end
					CLS_LEAD3: begin
						pend_n = SEQ_THREE;
						len_n  = SEQ_THREE;
						acc_n  = CP_W'(pop_item.data[3:0]);
					end
					CLS_LEAD4: begin
						pend_n = SEQ_FOUR;
						len_n  = SEQ_FOUR;
						acc_n  = CP_W'(pop_item.data[2:0]);
					end
					default: begin
						err_n = 1'b1;
					end
				endcase
			end else if (pop_item.cls != CLS_CONT) begin
				err_n = 1'b1;
			end else begin
				pend_n = pend_q - 1'b1;
				acc_n  = acc_sh;
				if (pend_q == SEQ_TWO) begin
					err_n = cp_bad;
					acc_n = '0;
					len_n = SEQ_NONE;
				end
			end
		end
	end

	// Result for this word
	always_comb begin
		if (pop_item.last) begin
			res_err   = err_n || !pop_item.present || (pend_n != SEQ_NONE);
			res_done  = 1'b1;
			res_valid = !res_err;
		end else begin
			res_err   = err_n;
			res_done  = 1'b0;
			res_valid = 1'b0;
		end
	end

	// Update decode state; clear at string end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= SEQ_NONE;
			len_q  <= SEQ_NONE;
			acc_q  <= '0;
			err_q  <= 1'b0;
		end else if (pop) begin
			if (pop_item.last) begin
				pend_q <= SEQ_NONE;
				len_q  <= SEQ_NONE;
				acc_q  <= '0;
				err_q  <= 1'b0;
			end else begin
				pend_q <= pend_n;
				len_q  <= len_n;
				acc_q  <= acc_n;
				err_q  <= err_n;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			err_out_q   <= res_err;
			done_out_q  <= res_done;
			valid_out_q <= res_valid;
		end
	end

	assign out_valid    = out_valid_q;
	assign error_seen   = err_out_q;
	assign string_done  = done_out_q;
	assign string_valid = valid_out_q;

endmodule

// ===== hdl/utf8v_checker.sv =====
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks on the validator's result words.
// ----------------------------------------------------------------------------
module utf8v_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic error_seen,
	input logic string_done,
	input logic string_valid
);

	// A verdict of valid only comes on a closing word
	a_valid_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_valid |-> string_done)
		else $error("string_valid without string_done");

	// A closing word's verdict is the inverse of its error flag
	a_verdict_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> (string_valid != error_seen))
		else $error("verdict disagrees with error_seen");

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_seen) &&
		$stable(string_done) && $stable(string_valid))
		else $error("result word dropped or changed while stalled");

	// Once an error shows within a string, it holds until the string closes
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && error_seen && !string_done ##1 out_valid |->
		error_seen)
		else $error("error cleared before string end");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.error_seen   (error_seen),
	.string_done  (string_done),
	.string_valid (string_valid)
);
